>>> rtl/upward_downward_band_compressor_unit_macros.svh
// Assertion helpers for the band compressor RTL.
`ifndef UPWARD_DOWNWARD_BAND_COMPRESSOR_UNIT_MACROS_SVH
`define UPWARD_DOWNWARD_BAND_COMPRESSOR_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define UDBC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define UDBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UDBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define UDBC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/udbc_pkg.sv
`timescale 1ns / 1ps
package udbc_pkg;

    localparam int CHANNELS    = 2;
    localparam int SAMPLE_BITS = 24;
    localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] REG_DOWN_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_RAT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_THR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UP_RAT    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_GAIN = 3'd6;

    // serial multiplier: 4-bit digits of the b operand per cycle
    localparam int MUL_AW   = 33;
    localparam int MUL_BW   = 36;
    localparam int MUL_PW   = MUL_AW + MUL_BW;
    localparam int MUL_DIG  = 4;
    localparam int MUL_STEP = MUL_BW / MUL_DIG;
    localparam int MUL_CW   = $clog2(MUL_STEP);

    localparam int DIV_NW = 36;
    localparam int DIV_DW = 8;
    localparam int DIV_CW = $clog2(DIV_NW);

    localparam logic [21:0] DB_PER_LOG2 = 22'd3945660;
    localparam logic [18:0] LOG2_PER_DB = 19'd278664;
    localparam logic [14:0] ENV_FLOOR   = 15'd21475;
    localparam logic signed [28:0] DB_OFFSET = 29'sd122315460;
    localparam logic [23:0] GAIN_MAX    = 24'hFFFFFF;
    localparam logic [23:0] UNITY       = 24'd4194304;
    localparam logic [7:0]  RATIO_MIN   = 8'd10;

    typedef enum logic [3:0] {
        S_IDLE, S_ENV, S_NORM, S_SQ, S_DB, S_CMP, S_RMUL, S_DIV,
        S_EMUL, S_POW, S_PMUL, S_NEXT, S_G1, S_G2, S_OUT, S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a;
        logic [MUL_BW-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              start;
        logic [DIV_NW-1:0] num;
        logic [DIV_DW-1:0] den;
    } t_div_req;

    // 2^(2^-(k+1)) in Q1.30
    function automatic logic [30:0] pow2_tab(input logic [3:0] k);
        logic [30:0] v;
        case (k)
            4'd0:    v = 31'd1518500250;
            4'd1:    v = 31'd1276901417;
            4'd2:    v = 31'd1170923762;
            4'd3:    v = 31'd1121280436;
            4'd4:    v = 31'd1097253708;
            4'd5:    v = 31'd1085434106;
            4'd6:    v = 31'd1079572136;
            4'd7:    v = 31'd1076653033;
            4'd8:    v = 31'd1075196443;
            4'd9:    v = 31'd1074468888;
            4'd10:   v = 31'd1074105294;
            4'd11:   v = 31'd1073923544;
            4'd12:   v = 31'd1073832680;
            4'd13:   v = 31'd1073787251;
            4'd14:   v = 31'd1073764537;
            default: v = 31'd1073753181;
        endcase
        return v;
    endfunction

endpackage

>>> rtl/udbc_if.sv
`timescale 1ns / 1ps
interface udbc_in_if;
    import udbc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          chan;
    modport source (output valid, sample_in, chan, input ready);
    modport sink   (input valid, sample_in, chan, output ready);
endinterface

interface udbc_out_if;
    import udbc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          chan_out;
    modport source (output valid, sample_out, chan_out, input ready);
    modport sink   (input valid, sample_out, chan_out, output ready);
endinterface

interface udbc_cfg_if;
    import udbc_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/upward_downward_band_compressor_unit.sv
`timescale 1ns / 1ps
// One band of an upward/downward compressor. Each item (sample, channel) updates that
// channel's peak envelope, turns it into a level in tenths of a dB, derives the downward
// cut and upward boost, and returns the sample scaled by both gains and the band gain,
// saturated. One item is in work at a time; the time from acceptance until its result is
// offered is set by the shared multiplier, which retires one 4-bit digit a cycle (one
// envelope update, sixteen squarings for the logarithm, one dB scaling, per active gain
// a ratio product, an exponent product and up to sixteen table products, three more for
// the output), by a 36-step bit-serial divider per active gain, and by a normalising
// shift. A stalled output adds its stall. A finished item waits in the output register
// while the next one is taken. Configuration writes are taken in any cycle.
`include "upward_downward_band_compressor_unit_macros.svh"
module upward_downward_band_compressor_unit (
    input logic        i_clk,
    input logic        i_rst_n,
    udbc_in_if.sink    i_in,
    udbc_cfg_if.sink   i_cfg,
    udbc_out_if.source o_out
);
    import udbc_pkg::*;

    localparam int SB = SAMPLE_BITS;

    // configuration
    logic signed [10:0] r_down_thr, r_up_thr;
    logic [7:0]         r_down_rat, r_up_rat;
    logic [30:0]        r_attack, r_release;
    logic [23:0]        r_band;

    t_state r_state, n_state;

    logic [30:0]       r_env_lvl [CHANNELS];
    logic [CH_W-1:0]   r_ch;
    logic              r_chan;
    logic              r_sneg;
    logic [SB-1:0]     r_mag;
    logic [30:0]       r_lvl;
    logic              r_eneg;
    logic [32:0]       r_x;
    logic [4:0]        r_p;
    logic [15:0]       r_frac;
    logic [3:0]        r_cnt;
    logic signed [28:0] r_d;
    logic              r_up;
    logic [7:0]        r_r;
    logic [15:0]       r_f;
    logic [4:0]        r_n;
    logic [31:0]       r_y;
    logic [4:0]        r_k;
    logic [23:0]       r_gd, r_gu;
    logic [SB-1:0]     r_res;
    logic              r_out_valid;
    logic [SB-1:0]     r_out_smp;
    logic              r_out_chan;

    t_mul_req          mul_req;
    t_div_req          div_req;
    logic              mul_done, div_done;
    logic [MUL_PW-1:0] mul_prod;
    logic [DIV_NW-1:0] div_quot;

    udbc_mul u_mul (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (mul_req),
        .o_done (mul_done),
        .o_prod (mul_prod)
    );

    udbc_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_done (div_done),
        .o_quot (div_quot)
    );

    // ---------------- input side ----------------
    logic            in_acc;
    logic [SB-1:0]   in_mag;
    logic [32:0]     lvl_raw;
    logic [30:0]     in_lvl;
    logic [CH_W-1:0] in_ch;
    logic [30:0]     env_old;
    logic            rising;
    logic [30:0]     coeff;
    logic [30:0]     emag;

    assign in_acc  = i_in.valid && i_in.ready;
    assign in_mag  = i_in.sample_in[SB-1] ? (~i_in.sample_in + 1'b1) : i_in.sample_in;
    assign lvl_raw = 33'(in_mag) << (32 - SB);
    assign in_lvl  = (lvl_raw > 33'h07FFFFFFF) ? 31'h7FFFFFFF : lvl_raw[30:0];
    assign in_ch   = (CHANNELS == 1) ? '0 : CH_W'(i_in.chan);
    assign env_old = r_env_lvl[in_ch];
    assign rising  = in_lvl > env_old;
    assign coeff   = rising ? r_attack : r_release;
    assign emag    = rising ? (in_lvl - env_old) : (env_old - in_lvl);

    // ---------------- envelope and log ----------------
    logic [62:0] m_round;
    logic [31:0] env_sum;
    logic [30:0] env_new;
    logic [32:0] sq_t;
    logic [32:0] x_nxt;
    logic [15:0] frac_nxt;

    // a rising input's product rounds up, so that the envelope floors the exact blend
    assign m_round  = {1'b0, mul_prod[61:0]} + 63'h7FFFFFFF;
    assign env_sum  = r_eneg ? (32'(r_lvl) - 32'(m_round[62:31]))
                             : (32'(r_lvl) + 32'(mul_prod[61:31]));
    assign env_new  = env_sum[30:0];
    assign sq_t     = mul_prod[63:31];
    assign x_nxt    = sq_t[32] ? {1'b0, sq_t[32:1]} : sq_t;
    assign frac_nxt = {r_frac[14:0], sq_t[32]};

    // ---------------- gain in dB ----------------
    logic signed [28:0] d_val;
    logic signed [10:0] thr_sel;
    logic signed [28:0] thr29;
    logic               cmp_hit;
    logic signed [28:0] gap;
    logic [7:0]         rat_sel, rat_eff;

    assign d_val   = signed'({2'b00, mul_prod[42:16]}) - DB_OFFSET;
    assign thr_sel = r_up ? r_up_thr : r_down_thr;
    assign thr29   = {{2{thr_sel[10]}}, thr_sel, 16'h0000};
    assign cmp_hit = r_up ? (r_d < thr29) : (r_d > thr29);
    assign gap     = r_up ? (thr29 - r_d) : (r_d - thr29);
    assign rat_sel = r_up ? r_up_rat : r_down_rat;
    assign rat_eff = (rat_sel < RATIO_MIN) ? RATIO_MIN : rat_sel;

    // ---------------- exponent ----------------
    logic [22:0] e_val;
    logic [7:0]  dn_n;
    logic [15:0] dn_f;
    logic [31:0] gd_sh;
    logic [32:0] gu_sh;
    logic [24:0] gu_raw;
    logic [23:0] gu_val;
    logic [27:0] g2;
    logic [23:0] g_sat;

    assign e_val  = mul_prod[46:24];
    assign dn_n   = 8'(e_val[22:16]) + 8'(|e_val[15:0]);
    assign dn_f   = 16'h0000 - e_val[15:0];
    assign gd_sh  = r_y >> (6'd8 + 6'(r_n));
    assign gu_sh  = {1'b0, r_y} << r_n[0];
    assign gu_raw = gu_sh[32:8];
    assign gu_val = gu_raw[24] ? GAIN_MAX : gu_raw[23:0];
    assign g2     = mul_prod[49:22];
    assign g_sat  = (|g2[27:24]) ? GAIN_MAX : g2[23:0];

    // ---------------- output value ----------------
    logic [SB:0]   pm;
    logic [SB:0]   lim;
    logic [SB-1:0] res_val;

    assign pm  = mul_prod[SB+22:22];
    assign lim = (SB+1)'(1) << (SB - 1);
    always_comb begin
        if (r_sneg) begin
            res_val = (pm > lim) ? lim[SB-1:0] : (~pm[SB-1:0] + 1'b1);
        end else begin
            res_val = (pm > lim - 1'b1) ? (lim[SB-1:0] - 1'b1) : pm[SB-1:0];
        end
    end

    logic out_free;
    assign out_free = !r_out_valid || o_out.ready;

    // ---------------- next state ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (in_acc) n_state = S_ENV;
            S_ENV:  if (mul_done) n_state = S_NORM;
            S_NORM: if (r_x[31] || r_p == 5'd0) n_state = S_SQ;
            S_SQ:   if (mul_done && r_cnt == 4'd15) n_state = S_DB;
            S_DB:   if (mul_done) n_state = S_CMP;
            S_CMP:  n_state = cmp_hit ? S_RMUL : S_NEXT;
            S_RMUL: if (mul_done) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_EMUL;
            S_EMUL: begin
                if (mul_done) begin
                    if (r_up ? (e_val[22:16] >= 7'd2) : (dn_n >= 8'd32)) n_state = S_NEXT;
                    else n_state = S_POW;
                end
            end
            S_POW: begin
                if (r_k == 5'd16) n_state = S_NEXT;
                else if (r_f[15]) n_state = S_PMUL;
            end
            S_PMUL: if (mul_done) n_state = S_POW;
            S_NEXT: n_state = r_up ? S_G1 : S_CMP;
            S_G1:   if (mul_done) n_state = S_G2;
            S_G2:   if (mul_done) n_state = S_OUT;
            S_OUT:  if (mul_done) n_state = S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------- unit requests ----------------
    always_comb begin
        mul_req    = '0;
        div_req    = '0;
        i_in.ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_in.ready    = 1'b1;
                mul_req.start = i_in.valid;
                mul_req.a     = MUL_AW'(coeff);
                mul_req.b     = MUL_BW'(emag);
            end
            S_NORM: begin
                mul_req.start = r_x[31] || r_p == 5'd0;
                mul_req.a     = r_x;
                mul_req.b     = MUL_BW'(r_x);
            end
            S_SQ: begin
                mul_req.start = mul_done;
                if (r_cnt == 4'd15) begin
                    mul_req.a = MUL_AW'({r_p, frac_nxt});
                    mul_req.b = MUL_BW'(DB_PER_LOG2);
                end else begin
                    mul_req.a = x_nxt;
                    mul_req.b = MUL_BW'(x_nxt);
                end
            end
            S_CMP: begin
                mul_req.start = cmp_hit;
                mul_req.a     = MUL_AW'(gap[27:0]);
                mul_req.b     = MUL_BW'(rat_eff - RATIO_MIN);
            end
            S_RMUL: begin
                div_req.start = mul_done;
                div_req.num   = mul_prod[DIV_NW-1:0];
                div_req.den   = r_r;
            end
            S_DIV: begin
                mul_req.start = div_done;
                mul_req.a     = MUL_AW'(div_quot[27:0]);
                mul_req.b     = MUL_BW'(LOG2_PER_DB);
            end
            S_POW: begin
                mul_req.start = (r_k != 5'd16) && r_f[15];
                mul_req.a     = MUL_AW'(r_y);
                mul_req.b     = MUL_BW'(pow2_tab(r_k[3:0]));
            end
            S_NEXT: begin
                mul_req.start = r_up;
                mul_req.a     = MUL_AW'(r_gd);
                mul_req.b     = MUL_BW'(r_gu);
            end
            S_G1: begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_AW'(mul_prod[47:22]);
                mul_req.b     = MUL_BW'(r_band);
            end
            S_G2: begin
                mul_req.start = mul_done;
                mul_req.a     = MUL_AW'(r_mag);
                mul_req.b     = MUL_BW'(g_sat);
            end
            default: ;
        endcase
    end

    // ---------------- configuration ----------------
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down_thr <= -11'sd200;
            r_down_rat <= 8'd30;
            r_up_thr   <= -11'sd400;
            r_up_rat   <= 8'd20;
            r_attack   <= 31'h7FFFFFFF;
            r_release  <= 31'h7FFFFFFF;
            r_band     <= UNITY;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                REG_DOWN_THR:  r_down_thr <= i_cfg.data[10:0];
                REG_DOWN_RAT:  r_down_rat <= i_cfg.data[7:0];
                REG_UP_THR:    r_up_thr   <= i_cfg.data[10:0];
                REG_UP_RAT:    r_up_rat   <= i_cfg.data[7:0];
                REG_ATTACK:    r_attack   <= i_cfg.data[30:0];
                REG_RELEASE:   r_release  <= i_cfg.data[30:0];
                REG_BAND_GAIN: r_band     <= i_cfg.data[23:0];
                default: ;
            endcase
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) r_env_lvl[i] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_ENV && mul_done) r_env_lvl[r_ch] <= env_new;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_ch   <= in_ch;
                    r_chan <= i_in.chan;
                    r_sneg <= i_in.sample_in[SB-1];
                    r_mag  <= in_mag;
                    r_lvl  <= in_lvl;
                    r_eneg <= rising;
                end
            end
            S_ENV: begin
                if (mul_done) begin
                    r_x <= 33'(32'(env_new) + 32'(ENV_FLOOR));
                    r_p <= 5'd31;
                end
            end
            S_NORM: begin
                if (r_x[31] || r_p == 5'd0) begin
                    r_cnt  <= '0;
                    r_frac <= '0;
                end else begin
                    r_x <= {r_x[31:0], 1'b0};
                    r_p <= r_p - 1'b1;
                end
            end
            S_SQ: begin
                if (mul_done) begin
                    r_x    <= x_nxt;
                    r_frac <= frac_nxt;
                    r_cnt  <= r_cnt + 1'b1;
                end
            end
            S_DB: begin
                if (mul_done) begin
                    r_d  <= d_val;
                    r_up <= 1'b0;
                end
            end
            S_CMP: begin
                r_r <= rat_eff;
                if (!cmp_hit) begin
                    if (r_up) r_gu <= UNITY;
                    else r_gd <= UNITY;
                end
            end
            S_EMUL: begin
                if (mul_done) begin
                    r_y <= 32'h40000000;
                    r_k <= '0;
                    if (r_up) begin
                        r_n <= 5'(e_val[22:16]);
                        r_f <= e_val[15:0];
                        if (e_val[22:16] >= 7'd2) r_gu <= GAIN_MAX;
                    end else begin
                        r_n <= dn_n[4:0];
                        r_f <= dn_f;
                        if (dn_n >= 8'd32) r_gd <= '0;
                    end
                end
            end
            S_POW: begin
                if (r_k == 5'd16) begin
                    if (r_up) r_gu <= gu_val;
                    else r_gd <= gd_sh[23:0];
                end else if (!r_f[15]) begin
                    // skip the table entry of a clear exponent bit
                    r_f <= {r_f[14:0], 1'b0};
                    r_k <= r_k + 1'b1;
                end
            end
            S_PMUL: begin
                if (mul_done) begin
                    r_y <= mul_prod[61:30];
                    r_f <= {r_f[14:0], 1'b0};
                    r_k <= r_k + 1'b1;
                end
            end
            S_NEXT: r_up <= 1'b1;
            S_OUT:  if (mul_done) r_res <= res_val;
            S_DONE: begin
                if (out_free) begin
                    r_out_smp  <= r_res;
                    r_out_chan <= r_chan;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_smp;
    assign o_out.chan_out   = r_out_chan;

    `UDBC_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_out_valid), "reset left block busy")
    `UDBC_ASSERT(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result shown without finished item")
    `UDBC_ASSERT(a_no_mul_idle, i_clk, i_rst_n, (r_state == S_IDLE) |-> !mul_done, "multiplier finished with no item in work")
    `UDBC_ASSERT(a_pow_bound, i_clk, i_rst_n, (r_state == S_PMUL) |-> (r_k < 5'd16), "exponent table walked past its end")
endmodule

>>> rtl/udbc_mul.sv
`timescale 1ns / 1ps
module udbc_mul (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  udbc_pkg::t_mul_req         i_req,
    output logic                       o_done,
    output logic [udbc_pkg::MUL_PW-1:0] o_prod
);
    import udbc_pkg::*;

    logic [MUL_AW-1:0]         r_a;
    logic [MUL_PW-1:0]         r_acc;
    logic [MUL_CW-1:0]         r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [MUL_AW+MUL_DIG-1:0] sum;

    // add one digit's partial product to the upper half, then move right a digit
    assign sum = {{MUL_DIG{1'b0}}, r_acc[MUL_PW-1:MUL_BW]}
               + ((MUL_AW+MUL_DIG)'(r_a) * (MUL_AW+MUL_DIG)'(r_acc[MUL_DIG-1:0]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == MUL_CW'(MUL_STEP - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= i_req.a;
            r_acc <= {{MUL_AW{1'b0}}, i_req.b};
        end else if (r_busy) begin
            r_acc <= {sum, r_acc[MUL_BW-1:MUL_DIG]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> rtl/udbc_div.sv
`timescale 1ns / 1ps
module udbc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  udbc_pkg::t_div_req          i_req,
    output logic                        o_done,
    output logic [udbc_pkg::DIV_NW-1:0] o_quot
);
    import udbc_pkg::*;

    logic [DIV_NW-1:0] r_q;
    logic [DIV_DW-1:0] r_rem;
    logic [DIV_DW-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIV_DW:0]   trial;
    logic [DIV_DW:0]   diff;
    logic              ge;

    // restoring division, one quotient bit a cycle
    assign trial = {r_rem, r_q[DIV_NW-1]};
    assign diff  = trial - {1'b0, r_den};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
            r_q   <= {r_q[DIV_NW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
endmodule

>>> test/udbc_tb_check.sv
`timescale 1ns / 1ps
module udbc_tb_check
    import udbc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    udbc_in_if   i_in,
    udbc_cfg_if  i_cfg,
    udbc_out_if  i_out,
    output int   o_errors,
    output int   o_pending
);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          chan_out;
    } t_result;

    localparam logic [30:0] ROOT2_Q30 [16] = '{
        31'd1518500250, 31'd1276901417, 31'd1170923762, 31'd1121280436,
        31'd1097253708, 31'd1085434106, 31'd1079572136, 31'd1076653033,
        31'd1075196443, 31'd1074468888, 31'd1074105294, 31'd1073923544,
        31'd1073832680, 31'd1073787251, 31'd1073764537, 31'd1073753181
    };
    localparam longint TENTHS_PER_OCT = 3945660;
    localparam longint OCT_PER_TENTH  = 278664;
    localparam longint ONE_Q22        = 4194304;
    localparam longint GAIN_TOP       = 64'hFFFFFF;

    logic [30:0]        env_level [CHANNELS];
    logic signed [10:0] dn_thr, up_thr;
    logic [7:0]         dn_rat, up_rat;
    logic [30:0]        att_c, rel_c;
    logic [23:0]        bgain;
    t_result            awaited_results [$];

    function automatic logic [63:0] log2_q16(logic [31:0] v);
        int          p;
        int          i;
        logic [63:0] x, fr;
        p = 31;
        while (p > 0 && !v[p]) p--;
        x  = {32'd0, v} << (31 - p);
        fr = 0;
        for (i = 0; i < 16; i++) begin
            x  = (x * x) >> 31;
            fr = fr << 1;
            if (x >= 64'h1_0000_0000) begin
                fr = fr | 1;
                x  = x >> 1;
            end
        end
        return 64'(p) * 65536 + fr;
    endfunction

    function automatic logic [63:0] exp2_frac(logic [63:0] f);
        logic [63:0] y;
        int          k;
        y = 64'd1 << 30;
        for (k = 0; k < 16; k++)
            if (f[15-k]) y = (y * 64'(ROOT2_Q30[k])) >> 30;
        return y;
    endfunction

    function automatic logic [63:0] boost_gain(logic [63:0] e);
        logic [63:0] n, g;
        n = e >> 16;
        if (n >= 2) return GAIN_TOP;
        g = (exp2_frac(e & 64'hFFFF) << n) >> 8;
        return (g > GAIN_TOP) ? GAIN_TOP : g;
    endfunction

    function automatic logic [63:0] cut_gain(logic [63:0] e);
        logic [63:0] n, f;
        n = e >> 16;
        f = e & 64'hFFFF;
        if (f != 0) begin
            n = n + 1;
            f = 65536 - f;
        end
        if (n + 8 >= 40) return 0;
        return exp2_frac(f) >> (8 + n);
    endfunction

    function automatic logic [63:0] tenths_to_oct(logic [63:0] diff, logic [7:0] ratio);
        logic [63:0] r, m;
        r = (ratio < 8'd10) ? 64'd10 : 64'(ratio);
        m = diff * (r - 10) / r;
        return (m * OCT_PER_TENTH) >> 24;
    endfunction

    function automatic t_result compress_sample(logic signed [SAMPLE_BITS-1:0] smp,
                                                logic ch);
        longint      s, d, td, tu, hi, res;
        logic [63:0] mag, lvl, env, c, gd, gu, g, pm;
        int          idx;
        t_result     r;
        s   = longint'(smp);
        idx = int'(ch) % CHANNELS;
        mag = (s < 0) ? 64'(-s) : 64'(s);
        lvl = mag << (32 - SAMPLE_BITS);
        if (lvl > 64'h7FFFFFFF) lvl = 64'h7FFFFFFF;
        env = 64'(env_level[idx]);
        c   = (lvl > env) ? 64'(att_c) : 64'(rel_c);
        env = (c * env + ((64'd1 << 31) - c) * lvl) >> 31;
        env_level[idx] = env[30:0];
        d  = longint'((log2_q16(32'(env + 21475)) * TENTHS_PER_OCT) >> 16)
             - 31 * TENTHS_PER_OCT;
        td = longint'(dn_thr) * 65536;
        tu = longint'(up_thr) * 65536;
        gd = ONE_Q22;
        gu = ONE_Q22;
        if (d > td) gd = cut_gain(tenths_to_oct(64'(d - td), dn_rat));
        if (d < tu) gu = boost_gain(tenths_to_oct(64'(tu - d), up_rat));
        g = (gd * gu) >> 22;
        g = (g * 64'(bgain)) >> 22;
        if (g > GAIN_TOP) g = GAIN_TOP;
        pm = (mag * g) >> 22;
        hi = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
        if (s < 0) res = (pm > 64'(hi + 1)) ? -hi - 1 : -longint'(pm);
        else       res = (pm > 64'(hi)) ? hi : longint'(pm);
        r.sample_out = res[SAMPLE_BITS-1:0];
        r.chan_out   = ch;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (env_level[i]) env_level[i] <= '0;
            dn_thr <= -11'sd200;
            dn_rat <= 8'd30;
            up_thr <= -11'sd400;
            up_rat <= 8'd20;
            att_c  <= 31'h7FFFFFFF;
            rel_c  <= 31'h7FFFFFFF;
            bgain  <= 24'd4194304;
            o_errors  <= 0;
            o_pending <= 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_DOWN_THR:  dn_thr <= i_cfg.data[10:0];
                    REG_DOWN_RAT:  dn_rat <= i_cfg.data[7:0];
                    REG_UP_THR:    up_thr <= i_cfg.data[10:0];
                    REG_UP_RAT:    up_rat <= i_cfg.data[7:0];
                    REG_ATTACK:    att_c  <= i_cfg.data[30:0];
                    REG_RELEASE:   rel_c  <= i_cfg.data[30:0];
                    REG_BAND_GAIN: bgain  <= i_cfg.data[23:0];
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready)
                awaited_results.push_back(compress_sample(i_in.sample_in, i_in.chan));
            if (i_out.valid && i_out.ready) begin
                if (awaited_results.size() == 0) begin
                    $display("%0t: unexpected result: sample_out %0d chan_out %0d", $time,
                             i_out.sample_out, i_out.chan_out);
                    o_errors <= o_errors + 1;
                end else begin
                    t_result exp_r;
                    exp_r = awaited_results.pop_front();
                    if (exp_r.sample_out !== i_out.sample_out ||
                        exp_r.chan_out !== i_out.chan_out) begin
                        $display("%0t: mismatch: expected sample_out %0d chan_out %0d, got %0d %0d",
                                 $time, exp_r.sample_out, exp_r.chan_out,
                                 i_out.sample_out, i_out.chan_out);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            o_pending <= awaited_results.size();
        end
    end

endmodule

>>> test/tb_upward_downward_band_compressor_unit.sv
`timescale 1ns / 1ps
module tb_upward_downward_band_compressor_unit;
    import udbc_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   awaited;
    bit   hold_rx;

    udbc_in_if  in_ch();
    udbc_cfg_if cfg_ch();
    udbc_out_if out_ch();

    upward_downward_band_compressor_unit uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .i_cfg  (cfg_ch),
        .o_out  (out_ch)
    );

    udbc_tb_check check (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (in_ch),
        .i_cfg    (cfg_ch),
        .i_out    (out_ch),
        .o_errors (fail_count),
        .o_pending(awaited)
    );

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    initial begin
        #120000000;
        $display("tb_upward_downward_band_compressor_unit: done, errors");
        $finish;
    end

    // receiver: switch among four stall styles at random, long hold-off on request
    initial begin
        int mode;
        int cyc;
        out_ch.ready = 1'b0;
        mode = 0;
        cyc  = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 256 == 0) mode = $urandom_range(0, 3);
            if (hold_rx) begin
                out_ch.ready <= 1'b0;
                repeat (3000) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                case (mode)
                    0:       out_ch.ready <= 1'b1;
                    1:       out_ch.ready <= $urandom_range(0, 1);
                    2:       out_ch.ready <= ($urandom_range(0, 7) == 0);
                    default: out_ch.ready <= (cyc % 7 < 3);
                endcase
            end
        end
    end

    task automatic push_sample(logic signed [SAMPLE_BITS-1:0] s, logic c);
        in_ch.valid     <= 1'b1;
        in_ch.sample_in <= s;
        in_ch.chan      <= c;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic pause_input(int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic drain;
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (awaited != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_all(int thr_d, int rat_d, int thr_u, int rat_u,
                             logic [30:0] att, logic [30:0] rel, logic [23:0] gn);
        logic [10:0] td, tu;
        td = thr_d[10:0];
        tu = thr_u[10:0];
        write_reg(REG_DOWN_THR, {20'd0, td});
        write_reg(REG_DOWN_RAT, 31'(rat_d[7:0]));
        write_reg(REG_UP_THR, {20'd0, tu});
        write_reg(REG_UP_RAT, 31'(rat_u[7:0]));
        write_reg(REG_ATTACK, att);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_BAND_GAIN, 31'(gn));
    endtask

    function automatic int pick_thr();
        case ($urandom_range(0, 4))
            0:       return -600;
            1:       return 0;
            2:       return int'($signed(11'($urandom)));
            default: return -int'($urandom_range(0, 600));
        endcase
    endfunction

    function automatic int pick_ratio();
        case ($urandom_range(0, 5))
            0:       return 10;
            1:       return 200;
            2:       return $urandom_range(0, 255);
            default: return $urandom_range(10, 200);
        endcase
    endfunction

    function automatic logic [30:0] pick_coeff();
        case ($urandom_range(0, 4))
            0:       return 31'd0;
            1:       return 31'h7FFFFFFF;
            2:       return 31'($urandom);
            default: return 31'h7FFFFFFF - 31'($urandom_range(1 << 18, 1 << 28));
        endcase
    endfunction

    function automatic logic [23:0] pick_gain();
        case ($urandom_range(0, 4))
            0:       return 24'd0;
            1:       return 24'hFFFFFF;
            2:       return 24'($urandom);
            default: return 24'($urandom_range(2097152, 8388608));
        endcase
    endfunction

    initial begin
        logic signed [SAMPLE_BITS-1:0] s;
        int burst, shape, phase, n;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.sample_in <= '0;
        in_ch.chan      <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= '0;
        cfg_ch.data     <= '0;
        hold_rx = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // field extremes at reset settings
        push_sample(-24'sd8388608, 1'b0);
        push_sample(24'sd8388607, 1'b1);
        push_sample(24'sd0, 1'b0);
        push_sample(24'sd1, 1'b1);
        push_sample(-24'sd1, 1'b0);
        drain();
        // fast attack, both thresholds crossed, each ratio set below unity once
        write_all(-600, 5, 0, 200, 31'd0, 31'd0, 24'hFFFFFF);
        push_sample(24'sd8388607, 1'b0);
        push_sample(-24'sd4000000, 1'b1);
        push_sample(24'sd300, 1'b0);
        drain();
        write_all(-600, 200, 0, 0, 31'd0, 31'h7FFFFFFF, 24'd4194304);
        push_sample(24'sd5000000, 1'b0);
        push_sample(-24'sd100000, 1'b1);
        drain();
        // huge upward boost on a quiet signal, zero band gain then max
        write_all(0, 200, 0, 200, 31'd0, 31'd0, 24'd0);
        push_sample(24'sd2, 1'b0);
        push_sample(-24'sd3, 1'b1);
        drain();
        write_reg(REG_BAND_GAIN, 31'hFFFFFF);
        push_sample(24'sd7, 1'b0);
        push_sample(-24'sd8388608, 1'b1);
        push_sample(24'sd40, 1'b0);
        drain();

        // random phases: envelope-shaped bursts under varied settings
        for (phase = 0; phase < 6; phase++) begin
            if (phase == 0) write_all(-600, 200, 0, 200, 31'h7FFFFFFF, 31'h7FFFFFFF, 24'd0);
            else if (phase == 5) write_all(0, 10, -600, 10, 31'd0, 31'd0, 24'hFFFFFF);
            else write_all(pick_thr(), pick_ratio(), pick_thr(), pick_ratio(),
                           pick_coeff(), pick_coeff(), pick_gain());
            n = 0;
            while (n < 250) begin
                burst = $urandom_range(1, 24);
                shape = $urandom_range(0, 23);
                if (phase == 2 && n == 100) hold_rx = 1'b1;
                repeat (burst) begin
                    case ($urandom_range(0, 9))
                        0:       s = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
                        1:       s = 24'($urandom);
                        default: s = $signed(24'($urandom)) >>> shape;
                    endcase
                    push_sample(s, 1'($urandom));
                    n++;
                end
                if ($urandom_range(0, 3) != 0) pause_input($urandom_range(1, 30));
            end
            drain();
        end

        drain();
        repeat (700) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_upward_downward_band_compressor_unit: done, clean");
        end else begin
            $display("tb_upward_downward_band_compressor_unit: done, errors");
        end
        $finish;
    end

endmodule
